### design/csvtlp_pkg.sv
// Package for the status,x,y line parser.
// Holds line-length constants, character codes, parser state and result types.
// No dependencies.
package csvtlp_pkg;

	localparam int LINE_MAX = 64;
	localparam int CNT_W    = $clog2(LINE_MAX);
	localparam int ACC_W    = 17;
	localparam int COORD_W  = 16;

	localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(LINE_MAX - 1);
	localparam logic [ACC_W-1:0] ACC_SAT   = 17'd65536;
	localparam logic [ACC_W-1:0] COORD_MAX = 17'd65535;

	// character codes
	localparam logic [7:0] CHR_NUL   = 8'h00;
	localparam logic [7:0] CHR_TAB   = 8'h09;
	localparam logic [7:0] CHR_LF    = 8'h0A;
	localparam logic [7:0] CHR_CR    = 8'h0D;
	localparam logic [7:0] CHR_SPACE = 8'h20;
	localparam logic [7:0] CHR_PLUS  = 8'h2B;
	localparam logic [7:0] CHR_COMMA = 8'h2C;
	localparam logic [7:0] CHR_MINUS = 8'h2D;
	localparam logic [7:0] CHR_ZERO  = 8'h30;
	localparam logic [7:0] CHR_NINE  = 8'h39;

	// number index within the line
	localparam logic [1:0] FIELD_STATUS = 2'd0;
	localparam logic [1:0] FIELD_X      = 2'd1;
	localparam logic [1:0] FIELD_Y      = 2'd2;

	// status codes
	localparam logic signed [1:0] STAT_NONE = 2'sb11;
	localparam logic signed [1:0] STAT_ZERO = 2'sb00;
	localparam logic signed [1:0] STAT_ONE  = 2'sb01;

	// position within one number
	typedef enum logic [1:0] {
		SUB_PRE   = 2'd0,
		SUB_SIGN  = 2'd1,
		SUB_DIG   = 2'd2,
		SUB_AFTER = 2'd3
	} sub_phase_t;

	typedef struct packed {
		logic [CNT_W-1:0]  cnt;
		logic [1:0]        idx;
		sub_phase_t        sub;
		logic              failed;
		logic              ended;
		logic              neg;
		logic [ACC_W-1:0]  accum;
		logic signed [1:0] hstat;
		logic [ACC_W-1:0]  hx;
	} parse_state_t;

	typedef struct packed {
		logic               emit;
		logic signed [1:0]  status;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} result_t;

	localparam parse_state_t ST_CLEAR = '{
		cnt:    '0,
		idx:    FIELD_STATUS,
		sub:    SUB_PRE,
		failed: 1'b0,
		ended:  1'b0,
		neg:    1'b0,
		accum:  '0,
		hstat:  STAT_ZERO,
		hx:     '0
	};

endpackage

### design/csvtlp_step.sv
// Next-state and result logic of the line parser for one received byte.
// Depends on csvtlp_pkg.
module csvtlp_step import csvtlp_pkg::*; (
	input  parse_state_t st,
	input  logic [7:0]   c,
	output parse_state_t nxt,
	output result_t      res
);

	logic             digit;
	logic             blank;
	logic [3:0]       dig;
	logic [20:0]      acc_x10;
	logic [ACC_W-1:0] acc_step;
	parse_state_t     fed;

	// End of a number at a comma: latch and check status or x and move on; after y, fail.
	function automatic parse_state_t finish_field(parse_state_t s);
		parse_state_t r;
		r = s;
		if (s.idx == FIELD_Y) begin
			r.failed = 1'b1;
		end else begin
			if (s.idx == FIELD_STATUS) begin
				if (s.accum == '0) begin
					r.hstat = STAT_ZERO;
				end else if (s.accum == 17'd1) begin
					r.hstat = s.neg ? STAT_NONE : STAT_ONE;
				end else begin
					r.failed = 1'b1;
				end
			end else begin
				if (s.hstat != STAT_NONE && s.neg && s.accum != '0) begin
					r.failed = 1'b1;
				end
				if (s.hstat != STAT_NONE && s.accum > COORD_MAX) begin
					r.failed = 1'b1;
				end
				r.hx = s.accum;
			end
			r.idx   = s.idx + 2'd1;
			r.sub   = SUB_PRE;
			r.accum = '0;
			r.neg   = 1'b0;
		end
		return r;
	endfunction

	assign digit = (c >= CHR_ZERO) && (c <= CHR_NINE);
	assign blank = (c == CHR_SPACE) || (c == CHR_TAB);
	assign dig   = c[3:0];

	// Multiply by ten with shifts, add the digit, saturate
	assign acc_x10  = ({4'd0, st.accum} << 3) + ({4'd0, st.accum} << 1) + 21'(dig);
	assign acc_step = (acc_x10 > 21'(ACC_SAT)) ? ACC_SAT : acc_x10[ACC_W-1:0];

	// Feed one counted byte to the number parser
	always_comb begin
		fed     = st;
		fed.cnt = st.cnt + CNT_W'(1);
		if (!st.failed && !st.ended) begin
			if (c == CHR_NUL) begin
				fed.ended = 1'b1;
			end else begin
				unique case (st.sub)
					SUB_PRE: begin
						if (blank) begin
							fed.sub = SUB_PRE;
						end else if (c == CHR_MINUS || c == CHR_PLUS) begin
							fed.neg = (c == CHR_MINUS);
							fed.sub = SUB_SIGN;
						end else if (digit) begin
							fed.accum = ACC_W'(dig);
							fed.sub   = SUB_DIG;
						end else begin
							fed.failed = 1'b1;
						end
					end
					SUB_SIGN: begin
						if (digit) begin
							fed.accum = ACC_W'(dig);
							fed.sub   = SUB_DIG;
						end else begin
							fed.failed = 1'b1;
						end
					end
					SUB_DIG: begin
						if (digit) begin
							fed.accum = acc_step;
						end else if (blank) begin
							fed.sub = SUB_AFTER;
						end else if (c == CHR_COMMA) begin
							fed = finish_field(fed);
						end else begin
							fed.failed = 1'b1;
						end
					end
					default: begin
						if (blank) begin
							fed.sub = SUB_AFTER;
						end else if (c == CHR_COMMA) begin
							fed = finish_field(fed);
						end else begin
							fed.failed = 1'b1;
						end
					end
				endcase
			end
		end
	end

	// Line control: ignore CR, judge on LF, drop overlong lines
	always_comb begin
		nxt        = st;
		res.emit   = 1'b0;
		res.status = STAT_ZERO;
		res.x      = '0;
		res.y      = '0;
		if (c == CHR_CR) begin
			nxt = st;
		end else if (c == CHR_LF) begin
			nxt = ST_CLEAR;
			if (st.cnt != '0 && !st.failed && st.idx == FIELD_Y &&
			    (st.sub == SUB_DIG || st.sub == SUB_AFTER)) begin
				if (st.hstat == STAT_NONE) begin
					res.emit   = 1'b1;
					res.status = STAT_NONE;
				end else if (!(st.neg && st.accum != '0) && st.accum <= COORD_MAX) begin
					res.emit   = 1'b1;
					res.status = st.hstat;
					res.x      = st.hx[COORD_W-1:0];
					res.y      = st.accum[COORD_W-1:0];
				end
			end
		end else if (st.cnt < CNT_LAST) begin
			nxt = fed;
		end else begin
			nxt = ST_CLEAR;
		end
	end

endmodule

### design/csv_triple_line_parser.sv
// Path: an item (byte) is registered in the input register, then parsed into the
// parser state and result registers; a result for a newline shows on res_valid.
// Throughput: one byte per cycle while the result register is free or drained; the
// parse step (multiply by ten, saturate) sits between the input register and the parser state and result registers.
// Reset: arst_n clears the pipeline valids and the parser to an empty line.
// Top level of the status,x,y line parser; depends on csvtlp_pkg, csvtlp_step.
module csv_triple_line_parser import csvtlp_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rx_valid,
	output logic                      rx_ready,
	input  logic [7:0]                rx_byte,
	output logic                      res_valid,
	input  logic                      res_ready,
	output logic signed [1:0]         target_status,
	output logic [COORD_W-1:0]        coord_x,
	output logic [COORD_W-1:0]        coord_y
);

	logic         valid_s1;
	logic [7:0]   byte_s1;
	parse_state_t state_q;
	parse_state_t state_nxt;
	result_t      step_res;
	logic         advance;
	logic         res_valid_q;
	logic signed [1:0]  status_q;
	logic [COORD_W-1:0] x_q;
	logic [COORD_W-1:0] y_q;

	// Advance the held item when the result register is free or being drained
	assign advance  = valid_s1 && (!res_valid_q || res_ready);
	assign rx_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_ready && rx_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	csvtlp_step u_step (
		.st  (state_q),
		.c   (byte_s1),
		.nxt (state_nxt),
		.res (step_res)
	);

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && step_res.emit) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step_res.emit) begin
			status_q <= step_res.status;
			x_q      <= step_res.x;
			y_q      <= step_res.y;
		end
	end

	assign res_valid     = res_valid_q;
	assign target_status = status_q;
	assign coord_x       = x_q;
	assign coord_y       = y_q;

	// Checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.cnt <= CNT_LAST)
		else $error("line byte count beyond limit");

	a_acc_sat: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.accum <= ACC_SAT)
		else $error("number accumulator above saturation");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && status_q == STAT_NONE |-> x_q == '0 && y_q == '0)
		else $error("no-target result with nonzero coordinates");

	a_from_lf: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(valid_s1 && byte_s1 == CHR_LF))
		else $error("result not caused by a newline");

endmodule

### bench/csv_triple_line_parser_test.sv
`timescale 1ns / 100ps
// Self-checking bench for csv_triple_line_parser: text lines go in byte by byte,
// and every status,x,y result is checked against a byte-level line parser in the bench.
// Depends on csvtlp_pkg and the csv_triple_line_parser RTL.
module csv_triple_line_parser_test import csvtlp_pkg::*; ();

	localparam int RANDOM_ITEMS = 1080;
	localparam int QUIET_ITEMS  = 900;
	localparam int HOLD_AFTER   = 500;
	localparam int LONG_HOLD    = 200;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 300000;

	typedef struct packed {
		logic signed [1:0]  status;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} target_t;

	// Line parser that predicts targets, and the queue of targets still due
	class target_scoreboard;
		int unsigned       line_len;
		logic [1:0]        num_idx;
		sub_phase_t        phase;
		bit                dropped;
		bit                stopped;
		bit                minus;
		int unsigned       magnitude;
		logic signed [1:0] status_hold;
		int unsigned       x_hold;
		target_t           due_targets[$];
		int                errors;
		int                checked;
		int                bytes_seen;
		int                lines_seen;

		function new();
			line_len = 0;
			errors = 0;
			checked = 0;
			bytes_seen = 0;
			lines_seen = 0;
			clear_line();
		endfunction

		function void clear_line();
			num_idx = FIELD_STATUS;
			phase = SUB_PRE;
			dropped = 0;
			stopped = 0;
			minus = 0;
			magnitude = 0;
			status_hold = STAT_ZERO;
			x_hold = 0;
		endfunction

		function void report(string msg);
			$display("MISMATCH: %s", msg);
			errors++;
		endfunction

		// latch the finished number and move on to the next one
		function void close_number();
			if (num_idx == FIELD_Y) begin
				dropped = 1;
				return;
			end
			if (num_idx == FIELD_STATUS) begin
				if (magnitude == 0)
					status_hold = STAT_ZERO;
				else if (magnitude == 1)
					status_hold = minus ? STAT_NONE : STAT_ONE;
				else
					dropped = 1;
			end else begin
				if (status_hold != STAT_NONE &&
				    ((minus && magnitude != 0) || magnitude > COORD_MAX))
					dropped = 1;
				x_hold = magnitude;
			end
			num_idx = num_idx + 2'd1;
			phase = SUB_PRE;
			magnitude = 0;
			minus = 0;
		endfunction

		function void parse_char(logic [7:0] c);
			bit digit;
			bit blank;
			digit = (c >= CHR_ZERO && c <= CHR_NINE);
			blank = (c == CHR_SPACE || c == CHR_TAB);
			if (dropped || stopped)
				return;
			if (c == CHR_NUL) begin
				stopped = 1;
				return;
			end
			case (phase)
				SUB_PRE: begin
					if (c == CHR_MINUS || c == CHR_PLUS) begin
						minus = (c == CHR_MINUS);
						phase = SUB_SIGN;
					end else if (digit) begin
						magnitude = c - CHR_ZERO;
						phase = SUB_DIG;
					end else if (!blank) begin
						dropped = 1;
					end
				end
				SUB_SIGN: begin
					if (digit) begin
						magnitude = c - CHR_ZERO;
						phase = SUB_DIG;
					end else begin
						dropped = 1;
					end
				end
				SUB_DIG: begin
					if (digit) begin
						magnitude = magnitude * 10 + (c - CHR_ZERO);
						if (magnitude > ACC_SAT)
							magnitude = ACC_SAT;
					end else if (blank) begin
						phase = SUB_AFTER;
					end else if (c == CHR_COMMA) begin
						close_number();
					end else begin
						dropped = 1;
					end
				end
				default: begin
					if (c == CHR_COMMA)
						close_number();
					else if (!blank)
						dropped = 1;
				end
			endcase
		endfunction

		// note one accepted byte; a newline may queue a target
		function void note_byte(logic [7:0] c);
			target_t t;
			bytes_seen++;
			if (c == CHR_CR)
				return;
			if (c == CHR_LF) begin
				lines_seen++;
				if (line_len > 0 && !dropped && num_idx == FIELD_Y &&
				    (phase == SUB_DIG || phase == SUB_AFTER)) begin
					if (status_hold == STAT_NONE) begin
						t.status = STAT_NONE;
						t.x = '0;
						t.y = '0;
						due_targets.push_back(t);
					end else if (!(minus && magnitude != 0) && magnitude <= COORD_MAX) begin
						t.status = status_hold;
						t.x = COORD_W'(x_hold);
						t.y = COORD_W'(magnitude);
						due_targets.push_back(t);
					end
				end
				line_len = 0;
				clear_line();
				return;
			end
			if (line_len < LINE_MAX - 1) begin
				line_len++;
				parse_char(c);
			end else begin
				// overlong line: drop the byte and start over
				line_len = 0;
				clear_line();
			end
		endfunction

		function void check_result(logic signed [1:0] s, logic [COORD_W-1:0] x,
		                           logic [COORD_W-1:0] y);
			target_t want;
			if (due_targets.size() == 0) begin
				report($sformatf("unexpected target %0d,%0d,%0d", s, x, y));
				return;
			end
			want = due_targets.pop_front();
			checked++;
			if (s !== want.status || x !== want.x || y !== want.y)
				report($sformatf("target %0d: got %0d,%0d,%0d, want %0d,%0d,%0d",
					checked, s, x, y, want.status, want.x, want.y));
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               rx_valid;
	logic               rx_ready;
	logic [7:0]         rx_byte;
	logic               res_valid;
	logic               res_ready;
	logic signed [1:0]  target_status;
	logic [COORD_W-1:0] coord_x;
	logic [COORD_W-1:0] coord_y;

	target_scoreboard sb;
	logic [7:0]       line_buf[$];
	int               items_sent;
	int               cycle_count;
	bit               quiet;
	bit               hold_done;

	csv_triple_line_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx_valid(rx_valid),
		.rx_ready(rx_ready),
		.rx_byte(rx_byte),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.target_status(target_status),
		.coord_x(coord_x),
		.coord_y(coord_y)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// watch both channels at the rising edge
	always @(posedge clk) begin
		if (arst_n && rx_valid && rx_ready)
			sb.note_byte(rx_byte);
		if (arst_n && res_valid && res_ready)
			sb.check_result(target_status, coord_x, coord_y);
	end

	// give up after a generous number of cycles
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	// receiver: random stalls, one long hold-off, none near the end
	initial begin
		res_ready = 0;
		hold_done = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!quiet && !hold_done && items_sent >= HOLD_AFTER) begin
				res_ready <= 0;
				repeat (LONG_HOLD) @(negedge clk);
				res_ready <= 1;
				hold_done = 1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				res_ready <= 0;
				repeat ($urandom_range(1, 16)) @(negedge clk);
				res_ready <= 1;
			end else begin
				res_ready <= 1;
			end
		end
	end

	// offer one byte, with an occasional gap before it; returns at a falling edge
	task send_byte(input logic [7:0] b);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			rx_valid <= 0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		rx_valid <= 1;
		rx_byte <= b;
		do @(posedge clk); while (!rx_ready);
		@(negedge clk);
		if (b != CHR_CR)
			items_sent++;
	endtask

	task send_line();
		foreach (line_buf[i])
			send_byte(line_buf[i]);
		line_buf.delete();
	endtask

	function void add_str(string s);
		foreach (s[i])
			line_buf.push_back(s[i]);
	endfunction

	function void add_blanks();
		int n;
		n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
		repeat (n)
			line_buf.push_back($urandom_range(0, 1) ? CHR_SPACE : CHR_TAB);
	endfunction

	function string status_text();
		case ($urandom_range(0, 11))
			0, 1:    return "-1";
			2:       return "0";
			3, 4:    return "1";
			5:       return "+1";
			6:       return "-0";
			7:       return "+0";
			8:       return "2";
			9:       return "-2";
			10:      return "01";
			default: return $sformatf("%0d", $urandom_range(0, 99999));
		endcase
	endfunction

	function string coord_text();
		case ($urandom_range(0, 11))
			0:       return "0";
			1:       return "65535";
			2:       return "65536";
			3:       return $sformatf("%0d", $urandom);
			4:       return $sformatf("-%0d", $urandom_range(0, 70000));
			5:       return "-0";
			6:       return $sformatf("+%0d", $urandom_range(0, 65535));
			7:       return $sformatf("00%0d", $urandom_range(0, 999));
			default: return $sformatf("%0d", $urandom_range(0, 65535));
		endcase
	endfunction

	// status,x,y with random blanks and an optional CR before the newline
	function void add_target_line();
		add_blanks();
		add_str(status_text());
		add_blanks();
		add_str(",");
		add_blanks();
		add_str(coord_text());
		add_blanks();
		add_str(",");
		add_blanks();
		add_str(coord_text());
		add_blanks();
		if ($urandom_range(0, 3) == 0)
			line_buf.push_back(CHR_CR);
		line_buf.push_back(CHR_LF);
	endfunction

	function void make_line();
		int kind;
		int pos;
		int n;
		kind = $urandom_range(0, 99);
		if (kind < 75) begin
			add_target_line();
			// corrupt some lines: stray byte, zero byte or CR somewhere
			if (kind >= 60) begin
				pos = $urandom_range(0, line_buf.size() - 2);
				case ($urandom_range(0, 2))
					0:       line_buf[pos] = 8'($urandom_range(0, 255));
					1:       line_buf.insert(pos, CHR_NUL);
					default: line_buf.insert(pos, CHR_CR);
				endcase
			end
		end else if (kind < 85) begin
			n = $urandom_range(1, 20);
			repeat (n)
				line_buf.push_back(8'($urandom_range(0, 255)));
			line_buf.push_back(CHR_LF);
		end else if (kind < 90) begin
			// filler around the line length limit, then a target line
			n = $urandom_range(LINE_MAX - 6, LINE_MAX + 4);
			repeat (n)
				line_buf.push_back($urandom_range(0, 1) ? CHR_SPACE : CHR_ZERO);
			add_target_line();
		end else if (kind < 95) begin
			if ($urandom_range(0, 1))
				line_buf.push_back(CHR_CR);
			line_buf.push_back(CHR_LF);
		end else begin
			case ($urandom_range(0, 5))
				0:       add_str("1,2\n");
				1:       add_str("1,2,3,4\n");
				2:       add_str("1,-,3\n");
				3:       add_str(",1,2\n");
				4:       add_str("1 2,3,4\n");
				default: add_str("0,5,6 ,\n");
			endcase
		end
	endfunction

	initial begin
		int base;
		sb = new();
		items_sent = 0;
		quiet = 0;
		arst_n = 0;
		rx_valid = 0;
		rx_byte = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// directed lines: extremes, blanks, signs and each special case
		add_str("1,0,0\n");
		add_str("-1,65535,9\r\n");
		add_str(" \t0 , 65535 ,\t65535 \t\n");
		add_str("\n");
		add_str("-0,-0,+0\n");
		add_str("1,65536,0\n");
		add_str("-1,-5,99999\n");
		add_str("1,2,3x\n");
		add_str("1,2,3");
		line_buf.push_back(CHR_NUL);
		add_str("junk\n");
		line_buf.push_back(8'hFF);
		line_buf.push_back(CHR_LF);
		repeat (LINE_MAX - 1)
			line_buf.push_back(CHR_SPACE);
		add_str("1,1,1\n");
		send_line();

		// random lines, with no idling in the last stretch
		base = items_sent;
		while (items_sent < base + RANDOM_ITEMS) begin
			if (items_sent >= base + QUIET_ITEMS)
				quiet = 1;
			make_line();
			send_line();
		end
		rx_valid <= 0;

		while (sb.due_targets.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Fed %0d bytes in %0d lines; %0d targets checked, %0d mismatches.",
			sb.bytes_seen, sb.lines_seen, sb.checked, sb.errors);
		$display("Receiver held off once for %0d cycles; run took %0d cycles.",
			LONG_HOLD, cycle_count);
		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

### files.f
design/csvtlp_pkg.sv
design/csvtlp_step.sv
design/csv_triple_line_parser.sv
bench/csv_triple_line_parser_test.sv
